// ===== rtl/placement_row_gap_finder_defines.svh =====
// Assertion macros for the placement row gap finder.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef PLACEMENT_ROW_GAP_FINDER_DEFINES_SVH
`define PLACEMENT_ROW_GAP_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRGF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRGF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prgf_pkg.sv =====
// Shared types and constants of the placement row gap finder.
// No dependencies; used by the top level.
`default_nettype none

package prgf_pkg;

  localparam int ROW_CAPACITY = 32;
  localparam int CNT_W        = $clog2(ROW_CAPACITY + 1);
  localparam int ADDR_W       = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;

  // One stored cell.
  typedef struct packed {
    logic [19:0]        w;
    logic signed [31:0] x;
    logic [15:0]        id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SCAN   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_GAP       = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_OUTSIDE   = 3'd4
  } status_t;

  localparam logic CFG_ROW_START = 1'b0;
  localparam logic CFG_ROW_END   = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/prgf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module prgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/placement_row_gap_finder.sv =====
// Top level of the placement row gap finder: sequencer, shared comparator, output register.
// Depends on prgf_pkg, prgf_ram and placement_row_gap_finder_defines.svh.
//
// Channel   Dir  Signals                              Contents (low bit first)
// s         in   s_tvalid s_tready s_tdata s_tuser    cell_id, cell_x, cell_width, pad; opcode
// m         out  m_tvalid m_tready m_tdata            gap_start, gap_end; m_tuser status; m_tlast
// cfg       in   cfg_we cfg_addr cfg_data             0 row_start, 1 row_end
//
// One operation is taken at a time; s_tready is high only while the sequencer is idle.
// Busy time is set by the single RAM read per step and the one shared 33-bit comparator:
// an insert walks the stored cells at or right of the new x, a remove or a scan every stored cell.
// A stall on the m side holds the sequencer only where a result must be sent.
// Reset clears the cell count and the row bounds; no clearing pass over the RAM is needed.
`default_nettype none
`include "placement_row_gap_finder_defines.svh"

module placement_row_gap_finder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] cell_id, [47:16] cell_x, [67:48] cell_width, [71:68] zero
  input  wire logic [71:0] s_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] gap_start, [63:32] gap_end
  output logic      [63:0] m_tdata,
  // [2:0] status
  output logic      [2:0]  m_tuser,
  output logic             m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_LO,
    S_INS_HI,
    S_INS_RD,
    S_INS_CHK,
    S_REM_RD,
    S_REM_CHK,
    S_SCN_RD,
    S_SCN_GAP,
    S_SCN_EDGE,
    S_SCN_FIN,
    S_REPLY
  } state_t;

  state_t                        state;
  logic signed [31:0]            row_start;
  logic signed [31:0]            row_end;
  logic [prgf_pkg::CNT_W-1:0]    count;
  logic [prgf_pkg::CNT_W-1:0]    idx;
  logic                          found;
  logic [15:0]                   in_id;
  logic signed [31:0]            in_x;
  logic [19:0]                   in_w;
  logic signed [32:0]            cur;
  prgf_pkg::status_t             reply_status;

  // RAM port signals.
  logic                          ram_we;
  logic [prgf_pkg::ADDR_W-1:0]   ram_waddr;
  prgf_pkg::entry_t              ram_wdata;
  logic                          ram_re;
  logic [prgf_pkg::ADDR_W-1:0]   ram_raddr;
  logic [prgf_pkg::ENTRY_W-1:0]  ram_rdata;

  prgf_pkg::entry_t              rd;
  prgf_pkg::entry_t              new_entry;
  logic [prgf_pkg::CNT_W-1:0]    idx_m1;
  logic signed [32:0]            rd_x_ext;
  logic signed [32:0]            rd_w_ext;
  logic signed [32:0]            edge_sum;
  logic signed [32:0]            cmp_a;
  logic signed [32:0]            cmp_b;
  logic                          lt;
  logic                          out_free;
  logic                          m_load;

  prgf_ram #(
    .WIDTH (prgf_pkg::ENTRY_W),
    .DEPTH (prgf_pkg::ROW_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd        = prgf_pkg::entry_t'(ram_rdata);
  assign new_entry = '{w: in_w, x: in_x, id: in_id};
  assign idx_m1    = idx - prgf_pkg::CNT_W'(1);
  assign rd_x_ext  = {rd.x[31], rd.x};
  assign rd_w_ext  = {13'd0, rd.w};
  assign edge_sum  = rd_x_ext + rd_w_ext;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  // A result transaction enters the output register in this cycle: a gap found by the
  // scan walk or the trailing gap, or the final reply of any operation.
  assign m_load = out_free && ((state == S_REPLY) ||
                  (lt && ((state == S_SCN_GAP) || (state == S_SCN_FIN))));

  // The one comparator of the block; each state that needs an ordering test selects
  // its operands here.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_INS_LO: begin
        cmp_a = {in_x[31], in_x};
        cmp_b = {row_start[31], row_start};
      end
      S_INS_HI: begin
        cmp_a = {row_end[31], row_end};
        cmp_b = {in_x[31], in_x};
      end
      S_INS_CHK: begin
        cmp_a = rd_x_ext;
        cmp_b = {in_x[31], in_x};
      end
      S_SCN_GAP: begin
        cmp_a = cur;
        cmp_b = rd_x_ext;
      end
      S_SCN_EDGE: begin
        cmp_a = cur;
        cmp_b = edge_sum;
      end
      S_SCN_FIN: begin
        cmp_a = cur;
        cmp_b = {row_end[31], row_end};
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign lt = (cmp_a < cmp_b);

  // RAM access. Insert walks down from the top, moving each entry at or right of the
  // new x up by one; remove walks up, moving each entry after the match down by one.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx[prgf_pkg::ADDR_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx[prgf_pkg::ADDR_W-1:0];
    ram_wdata = new_entry;
    case (state)
      S_INS_RD: begin
        ram_raddr = idx_m1[prgf_pkg::ADDR_W-1:0];
        ram_re    = (idx != '0);
        ram_we    = (idx == '0);
      end
      S_INS_CHK: begin
        ram_we    = 1'b1;
        ram_wdata = lt ? new_entry : rd;
      end
      S_REM_RD: begin
        ram_re = (idx != count);
      end
      S_REM_CHK: begin
        ram_we    = found;
        ram_waddr = idx_m1[prgf_pkg::ADDR_W-1:0];
        ram_wdata = rd;
      end
      S_SCN_RD: begin
        ram_re = (idx != count);
      end
      default: begin
        ram_re = 1'b0;
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      m_tvalid  <= 1'b0;
      row_start <= '0;
      row_end   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr[0])
          prgf_pkg::CFG_ROW_START: row_start <= cfg_data;
          prgf_pkg::CFG_ROW_END:   row_end   <= cfg_data;
          default:                 row_end   <= row_end;
        endcase
      end

      if (m_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_id <= s_tdata[15:0];
            in_x  <= s_tdata[47:16];
            in_w  <= s_tdata[67:48];
            idx   <= '0;
            found <= 1'b0;
            cur   <= {row_start[31], row_start};
            case (prgf_pkg::opcode_t'(s_tuser))
              prgf_pkg::OP_INSERT: state <= S_INS_LO;
              prgf_pkg::OP_REMOVE: state <= S_REM_RD;
              prgf_pkg::OP_SCAN:   state <= S_SCN_RD;
              default:             state <= S_IDLE;
            endcase
          end
        end

        S_INS_LO: begin
          if (lt) begin
            reply_status <= prgf_pkg::ST_OUTSIDE;
            state        <= S_REPLY;
          end else begin
            state <= S_INS_HI;
          end
        end

        S_INS_HI: begin
          if (lt) begin
            reply_status <= prgf_pkg::ST_OUTSIDE;
            state        <= S_REPLY;
          end else if (count == prgf_pkg::CNT_W'(prgf_pkg::ROW_CAPACITY)) begin
            reply_status <= prgf_pkg::ST_FULL;
            state        <= S_REPLY;
          end else begin
            idx   <= count;
            state <= S_INS_RD;
          end
        end

        S_INS_RD: begin
          if (idx == '0) begin
            count        <= count + prgf_pkg::CNT_W'(1);
            reply_status <= prgf_pkg::ST_DONE;
            state        <= S_REPLY;
          end else begin
            state <= S_INS_CHK;
          end
        end

        S_INS_CHK: begin
          if (lt) begin
            count        <= count + prgf_pkg::CNT_W'(1);
            reply_status <= prgf_pkg::ST_DONE;
            state        <= S_REPLY;
          end else begin
            idx   <= idx_m1;
            state <= S_INS_RD;
          end
        end

        S_REM_RD: begin
          if (idx == count) begin
            if (found) begin
              count        <= count - prgf_pkg::CNT_W'(1);
              reply_status <= prgf_pkg::ST_DONE;
            end else begin
              reply_status <= prgf_pkg::ST_NOT_FOUND;
            end
            state <= S_REPLY;
          end else begin
            state <= S_REM_CHK;
          end
        end

        S_REM_CHK: begin
          if (!found && (rd.id == in_id)) begin
            found <= 1'b1;
          end
          idx   <= idx + prgf_pkg::CNT_W'(1);
          state <= S_REM_RD;
        end

        S_SCN_RD: begin
          state <= (idx == count) ? S_SCN_FIN : S_SCN_GAP;
        end

        S_SCN_GAP: begin
          if (lt) begin
            if (out_free) begin
              m_tuser <= prgf_pkg::ST_GAP;
              m_tdata <= {rd.x, cur[31:0]};
              m_tlast <= 1'b0;
              state   <= S_SCN_EDGE;
            end
          end else begin
            state <= S_SCN_EDGE;
          end
        end

        S_SCN_EDGE: begin
          if (lt) begin
            cur <= edge_sum;
          end
          idx   <= idx + prgf_pkg::CNT_W'(1);
          state <= S_SCN_RD;
        end

        S_SCN_FIN: begin
          reply_status <= prgf_pkg::ST_DONE;
          if (lt) begin
            if (out_free) begin
              m_tuser <= prgf_pkg::ST_GAP;
              m_tdata <= {row_end, cur[31:0]};
              m_tlast <= 1'b0;
              state   <= S_REPLY;
            end
          end else begin
            state <= S_REPLY;
          end
        end

        S_REPLY: begin
          if (out_free) begin
            m_tuser <= reply_status;
            m_tdata <= '0;
            m_tlast <= 1'b1;
            state   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The cell count never passes the row capacity.
  `PRGF_ASSERT_IMPLIES(a_count_bound, 1'b1, count <= prgf_pkg::CNT_W'(prgf_pkg::ROW_CAPACITY), "cell count above capacity")

  // The cell count moves by at most one per cycle.
  `PRGF_ASSERT_IMPLIES(a_count_step, !$past(rst), (count == $past(count)) || (count == ($past(count) + 1'b1)) || (count == ($past(count) - 1'b1)), "cell count jumped")

  // A gap transaction is never the last result of an operation.
  `PRGF_ASSERT_IMPLIES(a_gap_not_last, m_tvalid && (m_tuser == prgf_pkg::ST_GAP), !m_tlast, "gap result marked last")

  // After a real operation is taken the block is busy on the next cycle.
  `PRGF_ASSERT_NEXT(a_busy_after_op, s_tvalid && s_tready && (s_tuser != prgf_pkg::OP_NONE), !s_tready, "ready right after accepting an operation")

endmodule

`default_nettype wire
